[rtl/core/dhfk_pkg.sv]
// Shared types, constants and tables for the DH chain forward kinematics block.
// No dependencies; every other file in rtl/core imports this package.
package dhfk_pkg;

   // chain geometry
   localparam int MAX_CHAIN_ATOMS = 1024;
   localparam int CNT_W           = $clog2(MAX_CHAIN_ATOMS);
   localparam int LEN_W           = 11;

   // stream payloads
   localparam int FLD_W  = 32;
   localparam int REQ_W  = 11 * FLD_W;
   localparam int RSP_W  = 3 * FLD_W;

   // datapath widths
   localparam int MUL_W  = 33;             // multiplier operand
   localparam int PROD_W = 2 * MUL_W;      // product register
   localparam int ACC_W  = PROD_W + 2;     // three-term accumulator
   localparam int DEL_W  = 42;             // dihedral change, rad Q14.28
   localparam int ANG_W  = DEL_W + 1;      // angle into the CORDIC
   localparam int CRD_W  = 34;             // CORDIC x/y/z

   // fixed-point constants
   localparam int DEG2RAD_K       = 18740330;
   localparam int TWO_PI_Q28      = 1686629713;
   localparam int PI_Q28          = 843314857;
   localparam int HALF_PI_Q28     = 421657428;
   localparam int CORDIC_GAIN_Q30 = 652032874;
   localparam int CORDIC_STEPS    = 30;
   localparam int RED_STEPS       = 12;    // range reduction compare-subtract steps
   localparam logic signed [FLD_W-1:0] ONE_Q30 = 32'sh4000_0000;

   // multiply groups
   localparam logic [2:0] OP_DELTA  = 3'd0;
   localparam logic [2:0] OP_BUILD  = 3'd1;
   localparam logic [2:0] OP_LINK   = 3'd2;
   localparam logic [2:0] OP_BRANCH = 3'd3;
   localparam logic [2:0] OP_OXY    = 3'd4;

   // CORDIC angle sources
   localparam logic [1:0] ANG_LINK_THETA = 2'd0;
   localparam logic [1:0] ANG_LINK_ALPHA = 2'd1;
   localparam logic [1:0] ANG_BR_THETA   = 2'd2;
   localparam logic [1:0] ANG_BR_ALPHA   = 2'd3;

   // column code of the translation term
   localparam logic [1:0] COL_T = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [2:0] op;
      logic [1:0] i;
      logic [1:0] j;
      logic [1:0] k;
   } dhfk_mul_type;

   typedef struct packed {
      logic         capture;
      dhfk_mul_type mul;
      logic         cordic_start;
      logic [1:0]   ang_sel;
      logic         load_out;
      logic         out_oxygen;
      logic         out_last;
      logic         commit;
      logic         commit_reset;
   } dhfk_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic cordic_done;
      logic out_free;
   } dhfk_status_type;

   // CORDIC rotation angle per step, Q30
   function automatic logic [30:0] atan_step(input logic [4:0] idx);
      logic [30:0] r;
      unique case (idx)
         5'd0:    r = 31'd843314857;
         5'd1:    r = 31'd497837829;
         5'd2:    r = 31'd263043837;
         5'd3:    r = 31'd133525159;
         5'd4:    r = 31'd67021687;
         5'd5:    r = 31'd33543516;
         5'd6:    r = 31'd16775851;
         5'd7:    r = 31'd8388437;
         5'd8:    r = 31'd4194283;
         5'd9:    r = 31'd2097149;
         5'd10:   r = 31'd1048576;
         default: r = 31'd1 << (5'd30 - idx);
      endcase
      return r;
   endfunction

endpackage

[rtl/core/dhfk_cordic.sv]
// Iterative sine/cosine unit: mod 2*pi reduction, quadrant fold, 30 CORDIC steps.
// Depends on dhfk_pkg.
module dhfk_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [dhfk_pkg::ANG_W-1:0]   angle,
   output logic                                done,
   output logic signed [dhfk_pkg::MUL_W-1:0]   sin_q,
   output logic signed [dhfk_pkg::MUL_W-1:0]   cos_q
);
   import dhfk_pkg::*;

   localparam logic [2:0] CS_IDLE = 3'd0;
   localparam logic [2:0] CS_RED  = 3'd1;
   localparam logic [2:0] CS_FOLD = 3'd2;
   localparam logic [2:0] CS_ITER = 3'd3;
   localparam logic [2:0] CS_DONE = 3'd4;

   localparam logic signed [CRD_W-1:0] K_TWO_PI  = CRD_W'(TWO_PI_Q28);
   localparam logic signed [CRD_W-1:0] K_PI      = CRD_W'(PI_Q28);
   localparam logic signed [CRD_W-1:0] K_HALF_PI = CRD_W'(HALF_PI_Q28);
   localparam logic signed [CRD_W-1:0] K_GAIN    = CRD_W'(CORDIC_GAIN_Q30);

   logic [2:0]                state_ff, state_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic [ANG_W-2:0]          mag_ff, mag_in;
   logic                      sgn_ff, sgn_in;
   logic                      neg_ff, neg_in;
   logic signed [CRD_W-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;

   logic signed [ANG_W-1:0]   abs_ang;
   logic [ANG_W-2:0]          sub;
   logic signed [CRD_W-1:0]   a0, a1, a2, xs, ys, stp, sin_w, cos_w;
   logic                      fneg;

   always_comb begin
      abs_ang = angle[ANG_W-1] ? -angle : angle;
      sub     = (ANG_W-1)'(TWO_PI_Q28) << cnt_ff[3:0];

      // residue is below 2*pi here
      a0 = sgn_ff ? -$signed(mag_ff[CRD_W-1:0]) : $signed(mag_ff[CRD_W-1:0]);
      if (a0 > K_PI) begin
         a1 = a0 - K_TWO_PI;
      end else if (a0 < -K_PI) begin
         a1 = a0 + K_TWO_PI;
      end else begin
         a1 = a0;
      end
      fneg = 1'b0;
      if (a1 > K_HALF_PI) begin
         a2   = a1 - K_PI;
         fneg = 1'b1;
      end else if (a1 < -K_HALF_PI) begin
         a2   = a1 + K_PI;
         fneg = 1'b1;
      end else begin
         a2 = a1;
      end

      xs  = x_ff >>> cnt_ff;
      ys  = y_ff >>> cnt_ff;
      stp = $signed({{(CRD_W-31){1'b0}}, atan_step(cnt_ff)});

      state_in = state_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      sgn_in   = sgn_ff;
      neg_in   = neg_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (start) begin
               mag_in   = abs_ang[ANG_W-2:0];
               sgn_in   = angle[ANG_W-1];
               cnt_in   = 5'(RED_STEPS - 1);
               state_in = CS_RED;
            end
         end
         CS_RED: begin
            if (mag_ff >= sub) begin
               mag_in = mag_ff - sub;
            end
            if (cnt_ff == 5'd0) begin
               state_in = CS_FOLD;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         CS_FOLD: begin
            x_in     = K_GAIN;
            y_in     = '0;
            z_in     = a2 <<< 2;
            neg_in   = fneg;
            cnt_in   = 5'd0;
            state_in = CS_ITER;
         end
         CS_ITER: begin
            if (z_ff >= 0) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - stp;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + stp;
            end
            if (cnt_ff == 5'(CORDIC_STEPS - 1)) begin
               state_in = CS_DONE;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         CS_DONE: state_in = CS_IDLE;
         default: state_in = CS_IDLE;
      endcase

      sin_w = neg_ff ? -y_ff : y_ff;
      cos_w = neg_ff ? -x_ff : x_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      sgn_ff <= sgn_in;
      neg_ff <= neg_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done  = (state_ff == CS_DONE);
   assign sin_q = sin_w[MUL_W-1:0];
   assign cos_q = cos_w[MUL_W-1:0];

endmodule

[rtl/core/dhfk_datapath.sv]
// Datapath: item capture, link matrix, transforms, shared multiplier and
// accumulator, output register. Depends on dhfk_pkg and dhfk_cordic.
module dhfk_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  dhfk_pkg::dhfk_cmd_type           cmd,
   output dhfk_pkg::dhfk_status_type        status,
   input  logic [dhfk_pkg::REQ_W-1:0]       req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dhfk_pkg::RSP_W-1:0]       rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import dhfk_pkg::*;

   localparam logic signed [ACC_W-1:0] RND30 = ACC_W'(2**29);
   localparam logic signed [ACC_W-1:0] RND18 = ACC_W'(2**17);

   // captured item
   logic signed [FLD_W-1:0] off_ff, twist_ff, dlen_ff;
   logic signed [FLD_W-1:0] boff_ff, btwist_ff, bdlen_ff, odlen_ff;
   logic signed [MUL_W-1:0] diff_ff;
   logic signed [DEL_W-1:0] delta_ff;

   // link matrix, rotation Q30
   logic signed [MUL_W-1:0] m_ff [3][3];

   // transforms
   logic signed [FLD_W-1:0] run_r_ff [9];
   logic signed [FLD_W-1:0] run_t_ff [3];
   logic signed [FLD_W-1:0] nxt_r_ff [9];
   logic signed [FLD_W-1:0] nxt_t_ff [3];
   logic signed [FLD_W-1:0] tcr_ff   [3];
   logic signed [FLD_W-1:0] tct_ff   [3];
   logic signed [FLD_W-1:0] ox_ff    [3];

   // multiplier pipe
   logic signed [MUL_W-1:0]  opa, opb;
   logic signed [PROD_W-1:0] prod_ff;
   dhfk_mul_type             pmul_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // output register
   logic                    rsp_valid_ff;
   logic signed [FLD_W-1:0] pos_ff [3];
   logic                    kind_ff, last_ff;

   // CORDIC
   logic [1:0]              ang_sel_ff;
   logic signed [ANG_W-1:0] ang;
   logic                    cdone;
   logic signed [MUL_W-1:0] csin, ccos;

   logic [3:0]              ridx;
   logic [1:0]              jj;
   logic signed [FLD_W-1:0] dsel;
   logic signed [ACC_W-1:0] pterm, acc_sum, r30, r18, tot;
   logic signed [FLD_W-1:0] addend, sat;
   logic                    first, term_last, fits;
   logic [3:0]              widx;

   dhfk_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cmd.cordic_start),
      .angle (ang),
      .done  (cdone),
      .sin_q (csin),
      .cos_q (ccos)
   );

   always_comb begin
      unique case (cmd.ang_sel)
         ANG_LINK_THETA: ang = ANG_W'(off_ff) - ANG_W'(delta_ff);
         ANG_LINK_ALPHA: ang = ANG_W'(twist_ff);
         ANG_BR_THETA:   ang = ANG_W'(boff_ff) - ANG_W'(delta_ff);
         ANG_BR_ALPHA:   ang = ANG_W'(btwist_ff);
         default:        ang = '0;
      endcase
   end

   // operand select
   always_comb begin
      jj   = (cmd.mul.j == COL_T) ? 2'd2 : cmd.mul.j;
      ridx = 4'(cmd.mul.i) * 4'd3 + 4'((cmd.mul.j == COL_T) ? 2'd2 : cmd.mul.k);
      dsel = (cmd.mul.op == OP_LINK) ? dlen_ff : bdlen_ff;
      opa  = '0;
      opb  = '0;
      unique case (cmd.mul.op)
         OP_DELTA: begin
            opa = diff_ff;
            opb = MUL_W'(DEG2RAD_K);
         end
         OP_BUILD: begin
            // sin theta sits in m10, cos theta in m00
            opa = cmd.mul.i[1] ? m_ff[0][0] : m_ff[1][0];
            opb = (cmd.mul.i == 2'd0 || cmd.mul.i == 2'd2) ? m_ff[2][2] : m_ff[2][1];
         end
         OP_LINK, OP_BRANCH: begin
            opa = MUL_W'(run_r_ff[ridx]);
            opb = (cmd.mul.j == COL_T) ? MUL_W'(dsel) : m_ff[cmd.mul.k][jj];
         end
         OP_OXY: begin
            opa = MUL_W'(tcr_ff[cmd.mul.i]);
            opb = MUL_W'(odlen_ff);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   // accumulate, round, saturate
   always_comb begin
      first     = (pmul_ff.k == 2'd0);
      term_last = (pmul_ff.k == 2'd2) || (pmul_ff.j == COL_T);
      pterm     = ACC_W'(prod_ff);
      if (pmul_ff.op == OP_BUILD && (pmul_ff.i == 2'd0 || pmul_ff.i == 2'd3)) begin
         pterm = -pterm;
      end
      acc_sum = (first ? '0 : acc_ff) + pterm;
      r30     = (acc_sum + RND30) >>> 30;
      r18     = (acc_sum + RND18) >>> 18;
      addend  = '0;
      if ((pmul_ff.op == OP_LINK || pmul_ff.op == OP_BRANCH) && pmul_ff.j == COL_T) begin
         addend = run_t_ff[pmul_ff.i];
      end else if (pmul_ff.op == OP_OXY) begin
         addend = tct_ff[pmul_ff.i];
      end
      tot  = r30 + ACC_W'(addend);
      fits = (&tot[ACC_W-1:FLD_W-1]) || !(|tot[ACC_W-1:FLD_W-1]);
      sat  = fits ? tot[FLD_W-1:0] : (tot[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);
      widx = 4'(pmul_ff.i) * 4'd3 + 4'(pmul_ff.j);
   end

   // architectural state and control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < 9; e++) begin
            run_r_ff[e] <= (e == 0 || e == 4 || e == 8) ? ONE_Q30 : '0;
         end
         for (int e = 0; e < 3; e++) begin
            run_t_ff[e] <= '0;
         end
         pmul_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.commit) begin
            for (int e = 0; e < 9; e++) begin
               if (cmd.commit_reset) begin
                  run_r_ff[e] <= (e == 0 || e == 4 || e == 8) ? ONE_Q30 : '0;
               end else begin
                  run_r_ff[e] <= nxt_r_ff[e];
               end
            end
            for (int e = 0; e < 3; e++) begin
               run_t_ff[e] <= cmd.commit_reset ? '0 : nxt_t_ff[e];
            end
         end
         pmul_ff <= cmd.mul;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         off_ff    <= req_tdata[0*FLD_W +: FLD_W];
         twist_ff  <= req_tdata[1*FLD_W +: FLD_W];
         dlen_ff   <= req_tdata[2*FLD_W +: FLD_W];
         diff_ff   <= MUL_W'($signed(req_tdata[3*FLD_W +: FLD_W]))
                    - MUL_W'($signed(req_tdata[4*FLD_W +: FLD_W]));
         boff_ff   <= req_tdata[5*FLD_W +: FLD_W];
         btwist_ff <= req_tdata[6*FLD_W +: FLD_W];
         bdlen_ff  <= req_tdata[7*FLD_W +: FLD_W];
         odlen_ff  <= req_tdata[10*FLD_W +: FLD_W];
         delta_ff  <= '0;
      end

      if (cmd.cordic_start) begin
         ang_sel_ff <= cmd.ang_sel;
      end
      if (cdone) begin
         if (!ang_sel_ff[0]) begin
            m_ff[0][0] <= ccos;
            m_ff[1][0] <= csin;
            m_ff[2][0] <= '0;
         end else begin
            m_ff[2][1] <= csin;
            m_ff[2][2] <= ccos;
         end
      end

      prod_ff <= opa * opb;

      if (pmul_ff.valid) begin
         acc_ff <= acc_sum;
         if (term_last) begin
            unique case (pmul_ff.op)
               OP_DELTA: delta_ff <= r18[DEL_W-1:0];
               OP_BUILD: begin
                  unique case (pmul_ff.i)
                     2'd0:    m_ff[0][1] <= r30[MUL_W-1:0];
                     2'd1:    m_ff[0][2] <= r30[MUL_W-1:0];
                     2'd2:    m_ff[1][1] <= r30[MUL_W-1:0];
                     default: m_ff[1][2] <= r30[MUL_W-1:0];
                  endcase
               end
               OP_LINK: begin
                  if (pmul_ff.j == COL_T) begin
                     nxt_t_ff[pmul_ff.i] <= sat;
                  end else begin
                     nxt_r_ff[widx] <= sat;
                  end
               end
               OP_BRANCH: begin
                  if (pmul_ff.j == COL_T) begin
                     tct_ff[pmul_ff.i] <= sat;
                  end else begin
                     tcr_ff[pmul_ff.i] <= sat;
                  end
               end
               OP_OXY:  ox_ff[pmul_ff.i] <= sat;
               default: ;
            endcase
         end
      end

      if (cmd.load_out) begin
         for (int e = 0; e < 3; e++) begin
            pos_ff[e] <= cmd.out_oxygen ? ox_ff[e] : nxt_t_ff[e];
         end
         kind_ff <= cmd.out_oxygen;
         last_ff <= cmd.out_last;
      end
   end

   assign status.pipe_busy   = pmul_ff.valid;
   assign status.cordic_done = cdone;
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {pos_ff[2], pos_ff[1], pos_ff[0]};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

[rtl/core/dhfk_ctrl.sv]
// Controller: sequences capture, CORDIC runs, multiply groups and output loads;
// holds the chain length register and link counter. Depends on dhfk_pkg.
module dhfk_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               csr_we,
   input  logic [dhfk_pkg::LEN_W-1:0]         csr_wdata,
   output dhfk_pkg::dhfk_cmd_type             cmd,
   input  dhfk_pkg::dhfk_status_type          status
);
   import dhfk_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DELTA  = 4'd1;
   localparam logic [3:0] S_LTH    = 4'd2;
   localparam logic [3:0] S_LAL    = 4'd3;
   localparam logic [3:0] S_LBUILD = 4'd4;
   localparam logic [3:0] S_LMUL   = 4'd5;
   localparam logic [3:0] S_LOUT   = 4'd6;
   localparam logic [3:0] S_BTH    = 4'd7;
   localparam logic [3:0] S_BAL    = 4'd8;
   localparam logic [3:0] S_BBUILD = 4'd9;
   localparam logic [3:0] S_BMUL   = 4'd10;
   localparam logic [3:0] S_OXY    = 4'd11;
   localparam logic [3:0] S_OOUT   = 4'd12;

   logic [3:0]       state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       ph_ff, ph_in;
   logic             last_ff, last_in, isc_ff, isc_in;
   logic             go_ff, go_in;
   logic [1:0]       i_ff, i_in, j_ff, j_in, k_ff, k_in;

   logic [LEN_W-1:0] lenc;
   logic             lastc, isc, use_delta;
   logic [2:0]       gop;
   logic [1:0]       ilast;
   logic             term_last;

   function automatic logic [1:0] jstart(input logic [2:0] op);
      logic [1:0] r;
      unique case (op)
         OP_LINK:   r = 2'd0;
         OP_BRANCH: r = 2'd2;
         default:   r = COL_T;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] group_of(input logic [3:0] st);
      logic [2:0] r;
      unique case (st)
         S_DELTA:            r = OP_DELTA;
         S_LBUILD, S_BBUILD: r = OP_BUILD;
         S_LMUL:             r = OP_LINK;
         S_BMUL:             r = OP_BRANCH;
         default:            r = OP_OXY;
      endcase
      return r;
   endfunction

   always_comb begin
      if (len_ff < LEN_W'(3)) begin
         lenc = LEN_W'(3);
      end else if (len_ff > LEN_W'(MAX_CHAIN_ATOMS)) begin
         lenc = LEN_W'(MAX_CHAIN_ATOMS);
      end else begin
         lenc = len_ff;
      end
      lastc     = (LEN_W'(cnt_ff) >= lenc - LEN_W'(1));
      isc       = (ph_ff == 2'd2);
      use_delta = (cnt_ff > CNT_W'(1)) && !lastc;

      gop       = group_of(state_ff);
      ilast     = (gop == OP_BUILD) ? 2'd3 : ((gop == OP_DELTA) ? 2'd0 : 2'd2);
      term_last = (k_ff == 2'd2) || (j_ff == COL_T);

      state_in = state_ff;
      len_in   = csr_we ? csr_wdata : len_ff;
      cnt_in   = cnt_ff;
      ph_in    = ph_ff;
      last_in  = last_ff;
      isc_in   = isc_ff;
      go_in    = go_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;

      cmd           = '0;
      cmd.mul.op    = gop;
      cmd.mul.i     = i_ff;
      cmd.mul.j     = j_ff;
      cmd.mul.k     = k_ff;
      cmd.ang_sel   = ANG_LINK_THETA;
      req_tready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               last_in     = lastc;
               isc_in      = isc;
               state_in    = use_delta ? S_DELTA : S_LTH;
            end
         end
         S_DELTA, S_LBUILD, S_LMUL, S_BBUILD, S_BMUL, S_OXY: begin
            if (go_ff) begin
               cmd.mul.valid = 1'b1;
               if (!term_last) begin
                  k_in = k_ff + 2'd1;
               end else begin
                  k_in = 2'd0;
                  if (j_ff != COL_T) begin
                     j_in = j_ff + 2'd1;
                  end else begin
                     j_in = jstart(gop);
                     i_in = i_ff + 2'd1;
                  end
               end
               if (term_last && j_ff == COL_T && i_ff == ilast) begin
                  go_in = 1'b0;
               end
            end else if (!status.pipe_busy) begin
               unique case (state_ff)
                  S_DELTA:  state_in = S_LTH;
                  S_LBUILD: state_in = S_LMUL;
                  S_LMUL:   state_in = S_LOUT;
                  S_BBUILD: state_in = S_BMUL;
                  S_BMUL:   state_in = S_OXY;
                  default:  state_in = S_OOUT;
               endcase
            end
         end
         S_LTH, S_LAL, S_BTH, S_BAL: begin
            unique case (state_ff)
               S_LTH:   cmd.ang_sel = ANG_LINK_THETA;
               S_LAL:   cmd.ang_sel = ANG_LINK_ALPHA;
               S_BTH:   cmd.ang_sel = ANG_BR_THETA;
               default: cmd.ang_sel = ANG_BR_ALPHA;
            endcase
            if (go_ff) begin
               cmd.cordic_start = 1'b1;
               go_in            = 1'b0;
            end else if (status.cordic_done) begin
               unique case (state_ff)
                  S_LTH:   state_in = S_LAL;
                  S_LAL:   state_in = S_LBUILD;
                  S_BTH:   state_in = S_BAL;
                  default: state_in = S_BBUILD;
               endcase
            end
         end
         S_LOUT, S_OOUT: begin
            if (status.out_free) begin
               cmd.load_out   = 1'b1;
               cmd.out_oxygen = (state_ff == S_OOUT);
               cmd.out_last   = (state_ff == S_OOUT) || !isc_ff;
               if (state_ff == S_LOUT && isc_ff) begin
                  state_in = S_BTH;
               end else begin
                  cmd.commit       = 1'b1;
                  cmd.commit_reset = last_ff;
                  cnt_in           = last_ff ? '0 : cnt_ff + CNT_W'(1);
                  ph_in            = (last_ff || ph_ff == 2'd2) ? 2'd0 : ph_ff + 2'd1;
                  state_in         = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // fresh issue flag and indices on every state change
      if (state_in != state_ff) begin
         go_in = 1'b1;
         i_in  = 2'd0;
         k_in  = 2'd0;
         j_in  = jstart(group_of(state_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= LEN_W'(3);
         cnt_ff   <= '0;
         ph_ff    <= 2'd0;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         ph_ff    <= ph_in;
         go_ff    <= go_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      isc_ff  <= isc_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
   end

endmodule

[rtl/core/dh_chain_forward_kinematics.sv]
// Top level of the DH chain forward kinematics block: controller plus datapath.
// Depends on dhfk_pkg, dhfk_ctrl, dhfk_datapath (and dhfk_cordic below it).
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  req     | in        | req_tvalid/req_tready  | req_tdata: one chain link item
//  rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata xyz, tuser kind, tlast
//  csr     | in        | csr_we                 | csr_wdata: chain_length
//
// One item at a time. Each CORDIC run goes through 12 reduction steps, fold,
// 30 rotations and done, and there are two per frame. A plain link has one
// frame, then 4 link matrix products and 30 link products; a carbonyl C link
// (counter mod 3 == 2) adds a branch frame, 4 more matrix products and 15 branch
// plus oxygen products, all through the one shared 33x33 multiplier, one per cycle.
// Reset is synchronous: chain length 3, identity transform, link counter 0.
// The next item is taken as soon as the last result sits in the output
// register; a stalled rsp side only holds the controller at an output load.
module dh_chain_forward_kinematics (
   input  logic                           clock,
   input  logic                           reset,
   // link_offset_angle, link_twist, link_length, new_dihedral_deg,
   // old_dihedral_deg, branch_c_offset_angle, branch_c_twist, branch_c_length,
   // oxygen_offset_angle, oxygen_twist, oxygen_length (32 bits each, low first)
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [dhfk_pkg::REQ_W-1:0]     req_tdata,
   // pos_x, pos_y, pos_z (32 bits each, low first)
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [dhfk_pkg::RSP_W-1:0]     rsp_tdata,
   // atom_kind: 0 backbone, 1 oxygen
   output logic                           rsp_tuser,
   // last_of_item
   output logic                           rsp_tlast,
   // chain_length
   input  logic                           csr_we,
   input  logic [dhfk_pkg::LEN_W-1:0]     csr_wdata
);
   import dhfk_pkg::*;

   dhfk_cmd_type    cmd;
   dhfk_status_type status;

   // sequencer: link counter, C-link phase, length clamp
   dhfk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

   // arithmetic, transforms and output register
   dhfk_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
